[rtl/gaussian_blur_5x5_rgb_defines.svh]
// assertion macros shared by the blur block
`ifndef GAUSSIAN_BLUR_5X5_RGB_DEFINES_SVH
`define GAUSSIAN_BLUR_5X5_RGB_DEFINES_SVH

// clocked assertion, quiet while reset is held
`define GB5_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define GB5_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/gb5_pkg.sv]
`default_nettype none

package gb5_pkg;

  localparam int unsigned NumCh    = 3;
  localparam int unsigned NumLines = 4;

  typedef logic [NumCh-1:0][7:0]  pix_t;
  typedef logic [NumCh-1:0][11:0] hsum_t;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_e;

  localparam logic [11:0] WidthReset  = 12'd640;
  localparam logic [11:0] HeightReset = 12'd480;
  localparam logic [11:0] MinSize     = 12'd5;
  localparam logic [11:0] HeightMax   = 12'd2048;

  // position flags of the pixel being taken
  typedef struct packed {
    logic in_win;  // column 4 or beyond: horizontal sum is valid
    logic vert;    // row 4 or beyond: together with in_win, an output is produced
    logic last;    // final pixel of the frame
  } pos_t;

  // horizontal 1,4,6,4,1 on one channel
  function automatic logic [11:0] hfir(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic [7:0] d,
                                       input logic [7:0] e);
    logic [11:0] ea, eb, ec, ed, ee;
    ea = 12'(a);
    eb = 12'(b);
    ec = 12'(c);
    ed = 12'(d);
    ee = 12'(e);
    return ea + (eb << 2) + (ec << 2) + (ec << 1) + (ed << 2) + ee;
  endfunction

  // vertical 1,4,6,4,1 over horizontal sums, scaled by 1/256
  function automatic logic [7:0] vfir(input logic [11:0] s0, input logic [11:0] s1,
                                      input logic [11:0] s2, input logic [11:0] s3,
                                      input logic [11:0] s4);
    logic [15:0] e0, e1, e2, e3, e4, acc;
    e0  = 16'(s0);
    e1  = 16'(s1);
    e2  = 16'(s2);
    e3  = 16'(s3);
    e4  = 16'(s4);
    acc = e0 + (e1 << 2) + (e2 << 2) + (e2 << 1) + (e3 << 2) + e4;
    return acc[15:8];
  endfunction

endpackage

`default_nettype wire

[rtl/gaussian_blur_5x5_rgb.sv]
`default_nettype none

// 5x5 binomial (1,4,6,4,1) blur of a raster RGB stream, each channel on its own,
// result floor(sum/256). One pixel is taken every clock while the output side
// does not stall it with tready low; each result passes the horizontal-sum
// register and then the output register. Frame size comes from the two
// configuration registers (any write restarts the frame at row 0, column 0),
// clamped to 5..MAX_WIDTH columns and 5..2048 rows. Only interior pixels are
// sent: an input at row r and column c, both at least 4, gives the output for
// (r-2, c-2), and tlast marks the last output of a frame. Horizontal sums go
// through a chain of four line cells, each a MAX_WIDTH x 36-bit memory with
// one read and one write per clock; the first four rows of every frame fill
// the chain, so no clearing pass is needed after reset.
module gaussian_blur_5x5_rgb
  import gb5_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [11:0] cfg_data_i,
  // pixel input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // pixel_c0, pixel_c1, pixel_c2
  // blurred output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // blur_c0, blur_c1, blur_c2
  output logic             m_axis_tlast    // frame_last
);

  `include "gaussian_blur_5x5_rgb_defines.svh"

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic           en, accept;
  pos_t           pos;
  logic [AW-1:0]  addr;
  pix_t           pix;
  pix_t           win_q [NumLines];
  hsum_t          hs;

  logic           v1_q, win1_q, vert1_q, last1_q;
  logic [AW-1:0]  addr1_q;
  hsum_t          hs1_q;
  hsum_t          line_rd [NumLines];
  hsum_t          line_wr [NumLines];
  logic           line_we;

  logic           out_vld_q;
  pix_t           out_data_q, vs;
  logic           out_last_q;

  assign cfg_ready_o   = 1'b1;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;
  assign pix           = s_axis_tdata;

  gb5_pos_ctrl #(
    .MaxWidth(MAX_WIDTH)
  ) u_pos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .adv_i      (accept),
    .pos_o      (pos),
    .addr_o     (addr)
  );

  // four previous pixels of the row, oldest in slot 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLines; i++) begin
        win_q[i] <= '0;
      end
    end else if (accept) begin
      for (int i = 0; i < NumLines - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[NumLines-1] <= pix;
    end
  end

  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      hs[ch] = hfir(win_q[0][ch], win_q[1][ch], win_q[2][ch], win_q[3][ch], pix[ch]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      win1_q  <= 1'b0;
      vert1_q <= 1'b0;
      last1_q <= 1'b0;
    end else if (en) begin
      v1_q    <= accept;
      win1_q  <= pos.in_win;
      vert1_q <= pos.vert && pos.in_win;
      last1_q <= pos.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr1_q <= addr;
      hs1_q   <= hs;
    end
  end

  // line chain: cell k holds row r-1-k and passes it on to cell k+1
  assign line_we = en && v1_q && win1_q;

  for (genvar k = 0; k < NumLines; k++) begin : g_line
    if (k == 0) begin : g_head
      assign line_wr[k] = hs1_q;
    end else begin : g_body
      assign line_wr[k] = line_rd[k-1];
    end

    gb5_line_cell #(
      .Depth(MAX_WIDTH),
      .DataW($bits(hsum_t))
    ) u_cell (
      .clk_i    (clk_i),
      .rd_en_i  (accept && pos.in_win),
      .rd_addr_i(addr),
      .rd_data_o(line_rd[k]),
      .wr_en_i  (line_we),
      .wr_addr_i(addr1_q),
      .wr_data_i(line_wr[k])
    );
  end

  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      vs[ch] = vfir(hs1_q[ch], line_rd[0][ch], line_rd[1][ch], line_rd[2][ch],
                    line_rd[3][ch]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= v1_q && vert1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= vs;
      out_last_q <= last1_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  `GB5_ASSERT(a_vert_to_out, (en && v1_q && vert1_q) |=> out_vld_q, "output lost")
  `GB5_ASSERT(a_vert_in_win, (v1_q && vert1_q) |-> win1_q, "output outside window")
  `GB5_ASSERT(a_last_is_out, (accept && pos.last) |-> (pos.vert && pos.in_win),
              "frame end not an output")
  `GB5_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> (!out_vld_q && !v1_q), "pipeline not empty")

endmodule

`default_nettype wire

[rtl/gb5_line_cell.sv]
`default_nettype none

// one row of horizontal sums; its read data feeds the next cell's write
module gb5_line_cell #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned DataW = 36,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [DataW-1:0] rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [DataW-1:0] wr_data_i
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[rtl/gb5_pos_ctrl.sv]
`default_nettype none

module gb5_pos_ctrl
  import gb5_pkg::*;
#(
  parameter int unsigned MaxWidth = 2048,
  localparam int unsigned AW      = $clog2(MaxWidth),
  localparam int unsigned CW      = (AW > 12) ? AW : 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [11:0]   cfg_data_i,
  input  wire logic          adv_i,
  output pos_t               pos_o,
  output logic      [AW-1:0] addr_o
);

  logic [11:0]   frame_width_q, frame_height_q;
  logic [CW-1:0] col_q, col_d;
  logic [10:0]   row_q, row_d;
  logic [31:0]   fw32, ew32;
  logic [CW-1:0] eff_w_m1, xcol;
  logic [11:0]   eff_h, eff_h_m1;
  logic          col_end, row_end;

  always_comb begin
    fw32 = 32'(frame_width_q);
    if (fw32 < 32'(MinSize)) begin
      ew32 = 32'(MinSize);
    end else if (fw32 > MaxWidth) begin
      ew32 = MaxWidth;
    end else begin
      ew32 = fw32;
    end
    eff_w_m1 = CW'(ew32 - 32'd1);

    if (frame_height_q < MinSize) begin
      eff_h = MinSize;
    end else if (frame_height_q > HeightMax) begin
      eff_h = HeightMax;
    end else begin
      eff_h = frame_height_q;
    end
    eff_h_m1 = eff_h - 12'd1;
  end

  assign col_end = (col_q == eff_w_m1);
  assign row_end = ({1'b0, row_q} == eff_h_m1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (adv_i) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? 11'd0 : row_q + 11'd1;
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WidthReset;
      frame_height_q <= HeightReset;
      col_q          <= '0;
      row_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
          CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
          default: ;
        endcase
      end
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // output column lags the input column by two
  assign xcol   = col_q - CW'(2);
  assign addr_o = xcol[AW-1:0];

  assign pos_o.in_win = (col_q >= CW'(4));
  assign pos_o.vert   = (row_q >= 11'd4);
  assign pos_o.last   = col_end && row_end;

endmodule

`default_nettype wire
